[design/lwsd_pkg.sv]
// Shared types and constants of the log word set decoder.
package lwsd_pkg;

    localparam int CHANNELS    = 32;
    localparam int CHAN_W      = 5;
    localparam int STORE_DEPTH = 1 << CHAN_W;
    localparam int VAL_W       = 10;
    localparam int MAG_W       = 9;
    localparam int HALF_BITS   = 14;
    localparam int TIME_W      = 31;
    localparam int SCALE_SHIFT = 3;

    localparam logic [1:0] CMD_LOG     = 2'd0;
    localparam logic [1:0] CMD_FLUSH   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam int STAMP_FLAG_BIT = 15;
    localparam int STAMP_HIGH_BIT = 14;
    localparam int CHAN_POS       = 10;

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] log_word;
    } word_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] set_time;
        logic              bad_signature;
        logic [CHAN_W-1:0] channel;
        logic              valid_res;
        logic [MAG_W-1:0]  magnitude;
        logic              negative;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [CHAN_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic              clear;
        logic              rd_en;
        logic [CHAN_W-1:0] rd_addr;
    } store_cmd_t;

    typedef struct packed {
        logic              set_open;
        logic              have_pending;
        logic [TIME_W-1:0] open_time;
        logic              open_bad;
    } set_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } dump_state_t;

endpackage

[design/lwsd_store.sv]
// Per-channel value memory with registered read and flip-flop valid bits.
module lwsd_store
    import lwsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_cmd_t       cmd,
    output logic             rd_valid,
    output logic [VAL_W-1:0] rd_value
);

    logic [VAL_W-1:0]       value_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]       rd_value_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            valid_reg[cmd.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            value_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_value_reg <= value_mem[cmd.rd_addr];
            rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_value = rd_value_reg;

endmodule

[design/lwsd_stamp.sv]
// Timestamp pairing and open-set state.
module lwsd_stamp
    import lwsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  word_req_t   req,
    output set_status_t status
);

    logic [15:0]       pending_reg, pending_next;
    logic              have_pending_reg, have_pending_next;
    logic              set_open_reg, set_open_next;
    logic [TIME_W-1:0] open_time_reg, open_time_next;
    logic              open_bad_reg, open_bad_next;

    logic              a_high;
    logic              b_high;
    logic [2*HALF_BITS-1:0] pair_time;

    always_comb
    begin
        a_high = pending_reg[STAMP_HIGH_BIT];
        b_high = req.log_word[STAMP_HIGH_BIT];
        if (a_high && !b_high)
        begin
            pair_time = {pending_reg[HALF_BITS-1:0], req.log_word[HALF_BITS-1:0]};
        end
        else if (b_high && !a_high)
        begin
            pair_time = {req.log_word[HALF_BITS-1:0], pending_reg[HALF_BITS-1:0]};
        end
        else
        begin
            pair_time = '0;
        end

        pending_next      = pending_reg;
        have_pending_next = have_pending_reg;
        set_open_next     = set_open_reg;
        open_time_next    = open_time_reg;
        open_bad_next     = open_bad_reg;

        if (take)
        begin
            unique case (req.command) inside
                CMD_FLUSH, CMD_RESTART:
                begin
                    set_open_next     = 1'b0;
                    have_pending_next = 1'b0;
                    pending_next      = '0;
                end
                CMD_LOG:
                begin
                    if (req.log_word[STAMP_FLAG_BIT])
                    begin
                        if (!have_pending_reg)
                        begin
                            // First half: any open set is closed by this word.
                            set_open_next     = 1'b0;
                            pending_next      = req.log_word;
                            have_pending_next = 1'b1;
                        end
                        else
                        begin
                            open_time_next    = {pair_time, {SCALE_SHIFT{1'b0}}};
                            open_bad_next     = (a_high == b_high);
                            set_open_next     = 1'b1;
                            have_pending_next = 1'b0;
                            pending_next      = '0;
                        end
                    end
                    else if (have_pending_reg)
                    begin
                        have_pending_next = 1'b0;
                        pending_next      = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= '0;
            have_pending_reg <= 1'b0;
            set_open_reg     <= 1'b0;
            open_time_reg    <= '0;
            open_bad_reg     <= 1'b0;
        end
        else
        begin
            pending_reg      <= pending_next;
            have_pending_reg <= have_pending_next;
            set_open_reg     <= set_open_next;
            open_time_reg    <= open_time_next;
            open_bad_reg     <= open_bad_next;
        end
    end

    assign status.set_open     = set_open_reg;
    assign status.have_pending = have_pending_reg;
    assign status.open_time    = open_time_reg;
    assign status.open_bad     = open_bad_reg;

endmodule

[design/log_word_set_decoder_top.sv]
// Log word set decoder: request decode, set dump sequencer and result register.
// A request that emits nothing leaves the decoder idle, so the next can follow at once.
// A request that emits a set gives 32 results, paced by the one-read-in-flight channel
// walk over the store memory and held back while the result register holds an untaken
// result; the next request is taken after the last result loads.
// Reset clears all control state and the valid bits at once; there is no clearing pass.
module log_word_set_decoder_top
    import lwsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  word_req_t item,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result
);

    dump_state_t       state_reg, state_next;
    logic [CHAN_W-1:0] ch_reg, ch_next;
    logic              inflight_reg, inflight_next;
    logic [CHAN_W-1:0] rd_ch_reg, rd_ch_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              take;
    logic              emit;
    logic              issue;
    logic              is_stamp;
    logic [CHAN_W-1:0] word_ch;
    store_cmd_t        store_cmd;
    set_status_t       status;
    logic              rd_valid;
    logic [VAL_W-1:0]  rd_value;

    lwsd_stamp u_stamp (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .req    (item),
        .status (status)
    );

    lwsd_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .rd_valid (rd_valid),
        .rd_value (rd_value)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign take       = item_valid && item_ready;
    assign is_stamp   = item.log_word[STAMP_FLAG_BIT];
    assign word_ch    = item.log_word[CHAN_POS +: CHAN_W];

    assign emit = take && status.set_open
                  && ((item.command == CMD_FLUSH) || ((item.command == CMD_LOG) && is_stamp));

    // Reads happen only while dumping and writes only while idle, so the two never meet.
    assign issue = (state_reg == ST_DUMP) && !inflight_reg && (!out_valid_reg || result_ready);

    always_comb
    begin
        store_cmd.wr_en   = take && (item.command == CMD_LOG) && !is_stamp
                            && !status.have_pending && status.set_open
                            && ({1'b0, word_ch} < (CHAN_W + 1)'(CHANNELS));
        store_cmd.wr_addr = word_ch;
        store_cmd.wr_data = item.log_word[VAL_W-1:0];
        store_cmd.clear   = take && (item.command == CMD_RESTART);
        store_cmd.rd_en   = issue;
        store_cmd.rd_addr = ch_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        inflight_next  = inflight_reg;
        rd_ch_next     = rd_ch_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = ST_DUMP;
                    ch_next    = '0;
                end
            end
            ST_DUMP:
            begin
                if (issue)
                begin
                    inflight_next = 1'b1;
                    rd_ch_next    = ch_reg;
                    ch_next       = ch_reg + 1'b1;
                end
                if (inflight_reg)
                begin
                    inflight_next          = 1'b0;
                    out_valid_next         = 1'b1;
                    out_next.set_time      = status.open_time;
                    out_next.bad_signature = status.open_bad;
                    out_next.channel       = rd_ch_reg;
                    out_next.valid_res     = rd_valid;
                    out_next.magnitude     = rd_valid ? rd_value[MAG_W-1:0] : '0;
                    out_next.negative      = rd_valid && rd_value[MAG_W];
                    out_next.last          = (rd_ch_reg == LAST_CHAN);
                    if (rd_ch_reg == LAST_CHAN)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ch_reg <= rd_ch_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[design/lwsd_checker.sv]
// Port-level checker for the log word set decoder, bound to the top level.
module lwsd_checker
    import lwsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input word_req_t item,
    input logic      result_valid,
    input logic      result_ready,
    input result_t   result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=> !item_ready)
        else $error("request taken in the middle of a set dump");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.command == CMD_RESTART) |=> item_ready)
        else $error("restart started a set dump");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_signature |-> result.set_time == '0)
        else $error("bad signature with non-zero time");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.valid_res |-> result.magnitude == '0 && !result.negative)
        else $error("invalid channel with non-zero value");

endmodule

bind log_word_set_decoder_top lwsd_checker u_lwsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
